FILE: rtl/core/ctpe_pkg.sv
// Shared types, constants and helper functions of the texture pixel expander.
`default_nettype none
package ctpe_pkg;

	// Palette size and address width.
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int IDX_W         = 8;

	// Output queue size.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Pixel format register codes.
	localparam logic [1:0] FMT_PAL4   = 2'd0;
	localparam logic [1:0] FMT_PAL8   = 2'd1;
	localparam logic [1:0] FMT_DIRECT = 2'd2;
	localparam logic [1:0] FMT_PACKED = 2'd3;

	// Input item kinds.
	localparam logic MODE_PAL_WR  = 1'b0;
	localparam logic MODE_TEXTURE = 1'b1;

	// Phases of the 24-bit packed format.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_EMIT   = 2'd2;

	// Alpha values.
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_SEMI   = 8'd200;
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

	typedef struct packed {
		logic             mode;
		logic             start_of_image;
		logic [IDX_W-1:0] palette_index;
		logic [15:0]      word;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_word;
	} out_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// One pixel request from the sequencer.
	typedef struct packed {
		logic              valid;
		logic              is_pal;
		logic [PAL_AW-1:0] addr;
		logic              oob;
		rgb_t              rgb;
		logic              last;
	} req_t;

	// One palette write.
	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [15:0]       data;
	} pal_wr_t;

	// Widens a 5-5-5 color to 8 bits per channel.
	function automatic rgb_t expand555(input logic [15:0] c);
		rgb_t x;
		x.r = {c[4:0], 3'b000};
		x.g = {c[9:5], 3'b000};
		x.b = {c[14:10], 3'b000};
		return x;
	endfunction

	// Alpha from the STP bit and the zero-color rule.
	function automatic logic [7:0] pal_alpha(input logic [15:0] c);
		logic zero;
		zero = (c[14:0] == 15'd0);
		if (c[15]) begin
			return zero ? ALPHA_OPAQUE : ALPHA_SEMI;
		end
		return zero ? ALPHA_CLEAR : ALPHA_OPAQUE;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ctpe_palette_ram.sv
// Palette memory: one write port, one read port with registered read data.
`default_nettype none
module ctpe_palette_ram
	import ctpe_pkg::*;
(
	input  wire logic              clk,
	input  wire pal_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [PAL_AW-1:0] rd_addr,
	output logic [15:0]            rd_data
);

	logic [15:0] mem [PALETTE_DEPTH];
	logic [15:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/core/ctpe_sequencer.sv
// Sequencer: holds one input item, writes the palette and issues one pixel per cycle while the output queue has space.
`default_nettype none
module ctpe_sequencer
	import ctpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire in_item_t   item,
	input  wire logic       space,
	output req_t            req,
	output pal_wr_t         pal_wr
);

	logic        busy_q;
	in_item_t    item_q;
	logic [1:0]  cnt_q;
	logic [1:0]  fmt_q;
	logic [1:0]  phase_q;
	logic [31:0] held_q;

	logic [1:0]       eff_phase;
	logic [1:0]       last_cnt;
	logic             emits;
	logic             step;
	logic             step_last;
	logic [IDX_W-1:0] idx;
	logic [7:0]       lo;
	logic [7:0]       hi;

	assign lo        = item_q.word[7:0];
	assign hi        = item_q.word[15:8];
	assign eff_phase = item_q.start_of_image ? PH_FIRST : phase_q;

	// Number of steps and whether they produce pixels.
	always_comb begin
		last_cnt = 2'd0;
		emits    = 1'b0;
		if (item_q.mode == MODE_TEXTURE) begin
			case (fmt_q)
				FMT_PAL4: begin
					last_cnt = 2'd3;
					emits    = 1'b1;
				end
				FMT_PAL8: begin
					last_cnt = 2'd1;
					emits    = 1'b1;
				end
				FMT_DIRECT: begin
					emits = 1'b1;
				end
				FMT_PACKED: begin
					if (eff_phase == PH_EMIT) begin
						last_cnt = 2'd1;
						emits    = 1'b1;
					end
				end
				default: begin
					emits = 1'b0;
				end
			endcase
		end
	end

	assign step       = busy_q && (!emits || space);
	assign step_last  = (cnt_q == last_cnt);
	assign item_ready = !busy_q || (step && step_last);

	// Palette index of the current pixel.
	always_comb begin
		idx = lo;
		if (fmt_q == FMT_PAL4) begin
			case (cnt_q)
				2'd0: idx = {4'd0, item_q.word[3:0]};
				2'd1: idx = {4'd0, item_q.word[7:4]};
				2'd2: idx = {4'd0, item_q.word[11:8]};
				default: idx = {4'd0, item_q.word[15:12]};
			endcase
		end else if (cnt_q != 2'd0) begin
			idx = hi;
		end
	end

	// Pixel request toward the palette and the output queue.
	always_comb begin
		req.valid = step && emits;
		req.is_pal = (fmt_q == FMT_PAL4) || (fmt_q == FMT_PAL8);
		req.addr  = idx[PAL_AW-1:0];
		req.oob   = ({1'b0, idx} >= (IDX_W + 1)'(PALETTE_DEPTH));
		req.last  = step_last;
		if (fmt_q == FMT_PACKED) begin
			if (cnt_q == 2'd0) begin
				req.rgb = '{r: held_q[7:0], g: held_q[15:8], b: held_q[23:16]};
			end else begin
				req.rgb = '{r: held_q[31:24], g: lo, b: hi};
			end
		end else begin
			req.rgb = expand555(item_q.word);
		end
	end

	// Palette write for a palette entry item.
	always_comb begin
		pal_wr.addr = item_q.palette_index[PAL_AW-1:0];
		pal_wr.data = item_q.word;
		pal_wr.en   = step && (item_q.mode == MODE_PAL_WR) &&
			({1'b0, item_q.palette_index} < (IDX_W + 1)'(PALETTE_DEPTH));
	end

	// Item holding register.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

	// Control state and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (item_valid && item_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (step && step_last) begin
				busy_q <= 1'b0;
				cnt_q  <= 2'd0;
			end else if (step) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Format register and 24-bit packing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_PAL4;
			phase_q <= PH_FIRST;
			held_q  <= 32'd0;
		end else if (cfg_wr_en) begin
			fmt_q   <= cfg_wr_data;
			phase_q <= PH_FIRST;
		end else if (step && step_last && item_q.mode == MODE_TEXTURE &&
				fmt_q == FMT_PACKED) begin
			case (eff_phase)
				PH_SECOND: begin
					held_q[31:16] <= {hi, lo};
					phase_q       <= PH_EMIT;
				end
				PH_EMIT: begin
					phase_q <= PH_FIRST;
				end
				default: begin
					held_q[15:0] <= {hi, lo};
					phase_q      <= PH_SECOND;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ctpe_out_queue.sv
// Output stage: takes palette read data, forms the pixel and queues it for transfer.
`default_nettype none
module ctpe_out_queue
	import ctpe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire req_t        req,
	input  wire logic [15:0] rd_data,
	output logic             space,
	output logic             pixel_valid,
	input  wire logic        pixel_ready,
	output out_item_t        pixel
);

	req_t             req_s1;
	logic             valid_s1;
	out_item_t        mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_AW:0]   count_q;

	logic [15:0] color;
	rgb_t        pal_rgb;
	out_item_t   push_item;
	logic        pop;

	// Request stage that lines up with the palette read latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			req_s1 <= req;
		end
	end

	// Pixel formation: palette entries get the STP alpha, direct pixels are opaque.
	always_comb begin
		color   = req_s1.oob ? 16'd0 : rd_data;
		pal_rgb = expand555(color);
		push_item.last_of_word = req_s1.last;
		if (req_s1.is_pal) begin
			push_item.red   = pal_rgb.r;
			push_item.green = pal_rgb.g;
			push_item.blue  = pal_rgb.b;
			push_item.alpha = pal_alpha(color);
		end else begin
			push_item.red   = req_s1.rgb.r;
			push_item.green = req_s1.rgb.g;
			push_item.blue  = req_s1.rgb.b;
			push_item.alpha = ALPHA_OPAQUE;
		end
	end

	// Room for one more request, counting the one in flight.
	assign space = ((OQ_AW + 2)'(count_q) + (OQ_AW + 2)'(valid_s1)) <
		(OQ_AW + 2)'(OQ_DEPTH);

	assign pixel_valid = (count_q != '0);
	assign pixel       = mem_q[rd_ptr_q];
	assign pop         = pixel_valid && pixel_ready;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			if (valid_s1 && !pop) begin
				count_q <= count_q + (OQ_AW + 1)'(1);
			end else if (pop && !valid_s1) begin
				count_q <= count_q - (OQ_AW + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/clut_texture_pixel_expander.sv
// Top level of the palette texture pixel expander.
//
// Palette writes and texture words enter on the item channel; RGBA pixels leave
// on the pixel channel. The sequencer handles one pixel per clock cycle while
// the output queue has room, so a 4-bit word gives four pixels, an 8-bit word
// two, a 16-bit word one, and three 24-bit words give two pixels, both issued
// for the third word; the first two words and palette writes issue no pixel.
// That rate is set by the single read port of the palette memory and the
// one-pixel-wide output. An issued pixel passes the registered palette read
// stage and then the output queue. The next item is taken in the cycle the
// current one issues its last pixel, and a four-entry output queue keeps the
// sequencer going while the consumer stalls briefly. Palette entries that were
// never written read as undefined.
`default_nettype none
module clut_texture_pixel_expander
	import ctpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire in_item_t   item,
	output logic            pixel_valid,
	input  wire logic       pixel_ready,
	output out_item_t       pixel
);

	req_t        req;
	pal_wr_t     pal_wr;
	logic        space;
	logic [15:0] rd_data;

	// Item sequencing and palette writes.
	ctpe_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.space       (space),
		.req         (req),
		.pal_wr      (pal_wr)
	);

	// Palette storage.
	ctpe_palette_ram u_ram (
		.clk     (clk),
		.wr      (pal_wr),
		.rd_en   (req.valid && req.is_pal),
		.rd_addr (req.addr),
		.rd_data (rd_data)
	);

	// Pixel formation and output queue.
	ctpe_out_queue u_oq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rd_data     (rd_data),
		.space       (space),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

	// A palette write and a pixel request never share a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pal_wr.en && req.valid))
		else $error("palette write collides with a pixel request");

	// No pixel is issued without room in the output queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		!space |-> !req.valid)
		else $error("pixel issued with the output queue full");

	// A pixel request is followed by a valid pixel on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |=> ##1 pixel_valid)
		else $error("issued pixel did not reach the output");

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the palette texture pixel expander.
module tb;
	import ctpe_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [1:0] cfg_wr_data;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      pixel_valid;
	logic      pixel_ready;
	out_item_t pixel;

	// Predictor state, updated at the edge where each transfer happens.
	logic [15:0] clut_copy [PALETTE_DEPTH];
	logic [1:0]  fmt_copy;
	logic [1:0]  phase_copy;
	logic [31:0] held_copy;
	out_item_t   pending_pixels [$];

	// Stimulus bookkeeping.
	bit  clut_loaded [PALETTE_DEPTH];
	int  burst_left;
	int  error_count;
	int  quiet_cycles;

	clut_texture_pixel_expander dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// A 1-5-5-5 color widened to 8 bits per channel.
	function automatic out_item_t color_pixel(logic [15:0] c, logic [7:0] a, logic last);
		out_item_t p;
		p.red          = 8'((c & 16'h001F) << 3);
		p.green        = 8'((c & 16'h03E0) >> 2);
		p.blue         = 8'((c & 16'h7C00) >> 7);
		p.alpha        = a;
		p.last_of_word = last;
		return p;
	endfunction

	// A palette lookup, with alpha from the STP bit and the all-zero color.
	function automatic out_item_t lookup_pixel(logic [7:0] idx, logic last);
		logic [15:0] c;
		logic [7:0]  a;
		c = clut_copy[idx];
		if (c[15])
			a = (c[14:0] == 15'd0) ? ALPHA_OPAQUE : ALPHA_SEMI;
		else
			a = (c[14:0] == 15'd0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
		return color_pixel(c, a, last);
	endfunction

	function automatic out_item_t rgb_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic last);
		out_item_t p;
		p.red          = r;
		p.green        = g;
		p.blue         = b;
		p.alpha        = ALPHA_OPAQUE;
		p.last_of_word = last;
		return p;
	endfunction

	// Works out the pixels that one accepted item produces.
	task automatic predict_pixels(input in_item_t it);
		logic [15:0] w;
		w = it.word;
		if (it.mode == MODE_PAL_WR) begin
			clut_copy[it.palette_index] = w;
		end else begin
			if (it.start_of_image)
				phase_copy = PH_FIRST;
			case (fmt_copy)
				FMT_PAL4: begin
					pending_pixels.push_back(lookup_pixel({4'd0, w[3:0]}, 1'b0));
					pending_pixels.push_back(lookup_pixel({4'd0, w[7:4]}, 1'b0));
					pending_pixels.push_back(lookup_pixel({4'd0, w[11:8]}, 1'b0));
					pending_pixels.push_back(lookup_pixel({4'd0, w[15:12]}, 1'b1));
				end
				FMT_PAL8: begin
					pending_pixels.push_back(lookup_pixel(w[7:0], 1'b0));
					pending_pixels.push_back(lookup_pixel(w[15:8], 1'b1));
				end
				FMT_DIRECT: begin
					pending_pixels.push_back(color_pixel(w, ALPHA_OPAQUE, 1'b1));
				end
				default: begin
					if (phase_copy == PH_SECOND) begin
						held_copy[31:16] = w;
						phase_copy = PH_EMIT;
					end else if (phase_copy == PH_EMIT) begin
						pending_pixels.push_back(rgb_pixel(held_copy[7:0], held_copy[15:8],
							held_copy[23:16], 1'b0));
						pending_pixels.push_back(rgb_pixel(held_copy[31:24], w[7:0], w[15:8],
							1'b1));
						phase_copy = PH_FIRST;
					end else begin
						held_copy[15:0] = w;
						phase_copy = PH_SECOND;
					end
				end
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	// Compares one pixel transfer with the oldest expected pixel.
	task automatic check_pixel(input out_item_t got);
		out_item_t want;
		if (pending_pixels.size() == 0) begin
			report_mismatch("unexpected pixel count", 1, 0);
		end else begin
			want = pending_pixels.pop_front();
			if (got.red !== want.red)
				report_mismatch("red", got.red, want.red);
			if (got.green !== want.green)
				report_mismatch("green", got.green, want.green);
			if (got.blue !== want.blue)
				report_mismatch("blue", got.blue, want.blue);
			if (got.alpha !== want.alpha)
				report_mismatch("alpha", got.alpha, want.alpha);
			if (got.last_of_word !== want.last_of_word)
				report_mismatch("last_of_word", got.last_of_word, want.last_of_word);
		end
	endtask

	// Monitor: the register write, item transfers and pixel transfers at each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				fmt_copy   = cfg_wr_data;
				phase_copy = PH_FIRST;
			end
			if (item_valid && item_ready)
				predict_pixels(item);
			if (pixel_valid && pixel_ready)
				check_pixel(pixel);
			if ((item_valid && item_ready) || (pixel_valid && pixel_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: stall style changes every so often.
	initial begin
		int style;
		int hold;
		int span;
		style = 0;
		hold = 0;
		span = 0;
		pixel_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				style = $urandom_range(2);
				span = $urandom_range(60, 200);
			end
			span--;
			if (hold > 0) begin
				hold--;
			end else begin
				case (style)
					0: pixel_ready = 1'b1;
					1: pixel_ready = ($urandom_range(3) != 0);
					default: begin
						pixel_ready = !pixel_ready;
						hold = pixel_ready ? $urandom_range(3) : $urandom_range(5);
					end
				endcase
			end
		end
	end

	// Watchdog on cycles with no transfer at all.
	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	// Sends one item; the sender works in bursts separated by random gaps.
	task automatic send_item(input logic mode, input logic sof, input logic [7:0] idx,
			input logic [15:0] w);
		int gap;
		@(negedge clk);
		item_valid = 1'b1;
		item.mode = mode;
		item.start_of_image = sof;
		item.palette_index = idx;
		item.word = w;
		if (mode == MODE_PAL_WR)
			clut_loaded[idx] = 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(5) == 0) ? 60 : $urandom_range(12);
		end
	endtask

	// Writes the format register once the block has drained.
	task automatic set_format(input logic [1:0] fmt);
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = fmt;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Picks a palette index in range that has already been written.
	function automatic logic [7:0] loaded_index(input int top);
		logic [7:0] idx;
		idx = 8'($urandom_range(top));
		while (!clut_loaded[idx])
			idx = 8'($urandom_range(top));
		return idx;
	endfunction

	// Alpha rule corners and 4-bit lookups; the start flag on a palette write is ignored.
	task automatic test_pal4_alpha();
		set_format(FMT_PAL4);
		send_item(MODE_PAL_WR, 1'b0, 8'd0, 16'h0000);
		send_item(MODE_PAL_WR, 1'b1, 8'd1, 16'h8000);
		send_item(MODE_PAL_WR, 1'b0, 8'd2, 16'h8001);
		send_item(MODE_PAL_WR, 1'b0, 8'd3, 16'h7FFF);
		send_item(MODE_PAL_WR, 1'b0, 8'd4, 16'hFFFF);
		send_item(MODE_PAL_WR, 1'b0, 8'd5, 16'h001F);
		send_item(MODE_PAL_WR, 1'b1, 8'd6, 16'h03E0);
		send_item(MODE_PAL_WR, 1'b0, 8'd7, 16'h7C00);
		send_item(MODE_TEXTURE, 1'b0, 8'd0, 16'h3210);
		send_item(MODE_TEXTURE, 1'b1, 8'hFF, 16'h7654);
	endtask

	// Lowest and highest palette indexes through the 8-bit format.
	task automatic test_pal8_extremes();
		set_format(FMT_PAL8);
		send_item(MODE_PAL_WR, 1'b0, 8'hFF, 16'hD6B5);
		send_item(MODE_PAL_WR, 1'b0, 8'h80, 16'h2A4A);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'hFF80);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'h00FF);
	endtask

	task automatic test_direct_extremes();
		set_format(FMT_DIRECT);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'h0000);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'hFFFF);
		send_item(MODE_TEXTURE, 1'b1, 8'h00, 16'h7FFF);
	endtask

	// 24-bit phases, a start flag that restarts a triple, and a format write mid-triple.
	task automatic test_packed_phases();
		set_format(FMT_PACKED);
		send_item(MODE_TEXTURE, 1'b1, 8'h00, 16'h2211);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'h4433);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'h6655);
		send_item(MODE_TEXTURE, 1'b1, 8'h00, 16'hFFFF);
		send_item(MODE_TEXTURE, 1'b1, 8'h00, 16'h0000);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'hA5C3);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'h00FF);
		send_item(MODE_TEXTURE, 1'b1, 8'h00, 16'h1234);
		set_format(FMT_PACKED);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'hFF00);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'h0F0F);
		send_item(MODE_TEXTURE, 1'b0, 8'h00, 16'hF0F0);
	endtask

	// Random traffic under one format: palette rewrites mixed with texture words.
	task automatic test_random_format(input logic [1:0] fmt, input int count);
		logic [15:0] w;
		logic [7:0]  idx;
		logic [7:0]  n0;
		logic [7:0]  n1;
		logic [7:0]  n2;
		logic [7:0]  n3;
		int          n;
		int          kind;
		set_format(fmt);
		n = 0;
		while (n < count) begin
			kind = $urandom_range(9);
			w = 16'($urandom);
			if (kind < 2) begin
				idx = ($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
				send_item(MODE_PAL_WR, 1'($urandom), idx, w);
				n++;
			end else if (fmt == FMT_PAL4) begin
				n0 = loaded_index(15);
				n1 = loaded_index(15);
				n2 = loaded_index(15);
				n3 = loaded_index(15);
				w = {n0[3:0], n1[3:0], n2[3:0], n3[3:0]};
				send_item(MODE_TEXTURE, 1'($urandom), 8'($urandom), w);
				n++;
			end else if (fmt == FMT_PAL8) begin
				w = {loaded_index(255), loaded_index(255)};
				send_item(MODE_TEXTURE, 1'($urandom), 8'($urandom), w);
				n++;
			end else if (fmt == FMT_DIRECT || kind == 9) begin
				// A stray word with a random start flag breaks the 24-bit triples.
				send_item(MODE_TEXTURE, 1'($urandom), 8'($urandom), w);
				n++;
			end else begin
				send_item(MODE_TEXTURE, 1'b1, 8'($urandom), w);
				send_item(MODE_TEXTURE, 1'b0, 8'($urandom), 16'($urandom));
				send_item(MODE_TEXTURE, 1'b0, 8'($urandom), 16'($urandom));
				n += 3;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = FMT_PAL4;
		item_valid = 1'b0;
		item = '0;
		fmt_copy = FMT_PAL4;
		phase_copy = PH_FIRST;
		held_copy = '0;
		error_count = 0;
		burst_left = 0;
		foreach (clut_loaded[i])
			clut_loaded[i] = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_pal4_alpha();
		test_pal8_extremes();
		test_direct_extremes();
		test_packed_phases();
		test_random_format(FMT_PAL4, 30);
		test_random_format(FMT_PAL8, 30);
		test_random_format(FMT_DIRECT, 25);
		test_random_format(FMT_PACKED, 30);
		test_random_format(FMT_PAL8, 30);
		test_random_format(FMT_PAL4, 25);
		test_random_format(FMT_PACKED, 25);
		test_random_format(FMT_DIRECT, 25);

		// Drain every expected pixel, then give the block time for any stray output.
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
